[rtl/alm_pkg.sv]
// Shared types and codes for the array linked list manager.
// No dependencies.
`default_nettype none

package alm_pkg;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;
   localparam logic [1:0] STATUS_BAD   = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_LINK,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

[rtl/alm_req_if.sv]
// Request channel: command item with valid/ready handshake.
// No dependencies.
`default_nettype none

interface alm_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [31:0] value;
   logic [7:0]         position;

   modport source (output valid, output cmd, output value, output position, input ready);
   modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

`default_nettype wire

[rtl/alm_rsp_if.sv]
// Response channel: status item with valid/ready handshake.
// No dependencies.
`default_nettype none

interface alm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] slot;

   modport source (output valid, output status, output slot, input ready);
   modport sink   (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

[rtl/alm_ram.sv]
// Simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none

module alm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/array_linked_list_manager.sv]
// Array linked list manager: circular doubly linked list over slot memories.
// Depends on alm_pkg, alm_req_if, alm_rsp_if, alm_ram.
//
// Usage:
//   req_chan carries one command item: cmd (insert at tail / delete slot),
//   value (stored on insert) and position (slot to delete). rsp_chan returns
//   exactly one item per command: status and the slot used or freed.
//   Link, back-link and in-use bits sit in three RAMs with registered reads;
//   the sentinel's head and tail links are held in registers.
//   One command at a time: accept, read, write the slot, patch the neighbour
//   links, then load the response register. A new item is taken only once
//   the previous command has loaded its response; a full/empty/bad-position
//   answer found at accept skips the write and link steps, an in-use mismatch
//   skips the link step. On success a command passes through the EXEC, LINK
//   and RESP states. Reset starts a clearing pass over all SLOT_COUNT slots
//   that rebuilds the free chain; req_chan.ready stays low until it ends.
//   If the receiver stalls, the response register holds its item and the
//   block finishes the next command up to its response, then waits.
`default_nettype none

module array_linked_list_manager #(
   parameter int SLOT_COUNT = 256,
   parameter int DATA_WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   alm_req_if.sink   req_chan,
   alm_rsp_if.source rsp_chan
);

   localparam int IW = $clog2(SLOT_COUNT);
   localparam logic [IW-1:0] LAST_SLOT = IW'(SLOT_COUNT - 1);

   alm_pkg::state_type state_ff, state_in;

   logic               cmd_ff, cmd_in;
   logic signed [31:0] value_ff, value_in;
   logic [IW-1:0]      slot_ff, slot_in;
   logic [1:0]         status_ff, status_in;
   logic [IW-1:0]      free_head_ff, free_head_in;
   logic [IW-1:0]      head_next_ff, head_next_in;
   logic [IW-1:0]      tail_ff, tail_in;
   logic [IW-1:0]      clear_idx_ff, clear_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [7:0]         rsp_slot_ff, rsp_slot_in;

   logic [DATA_WIDTH-1:0] value_mem [SLOT_COUNT];
   logic                  value_we;

   logic          nx_we, pv_we, us_we;
   logic [IW-1:0] nx_wa, pv_wa, us_wa;
   logic [IW-1:0] nx_wd, pv_wd;
   logic          us_wd;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] nx_rd, pv_rd;
   logic          us_rd;

   logic       accept;
   logic       pos_bad;
   logic [1:0] acc_status;
   logic       exec_fail;
   logic       out_free;

   alm_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_wa),
      .wr_data (nx_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (nx_rd)
   );

   alm_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_prev_ram (
      .clock   (clock),
      .wr_en   (pv_we),
      .wr_addr (pv_wa),
      .wr_data (pv_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (pv_rd)
   );

   alm_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_use_ram (
      .clock   (clock),
      .wr_en   (us_we),
      .wr_addr (us_wa),
      .wr_data (us_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (us_rd)
   );

   assign req_chan.ready = (state_ff == alm_pkg::ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign pos_bad = (req_chan.position == 8'd0) || (32'(req_chan.position) >= SLOT_COUNT);

   always_comb begin
      if (req_chan.cmd == alm_pkg::CMD_INSERT) begin
         acc_status = (free_head_ff == '0) ? alm_pkg::STATUS_FULL : alm_pkg::STATUS_OK;
      end else if (head_next_ff == '0) begin
         acc_status = alm_pkg::STATUS_EMPTY;
      end else if (pos_bad) begin
         acc_status = alm_pkg::STATUS_BAD;
      end else begin
         acc_status = alm_pkg::STATUS_OK;
      end
   end

   // insert needs a free slot, delete needs a slot in use
   assign exec_fail = (cmd_ff == alm_pkg::CMD_INSERT) ? us_rd : !us_rd;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         alm_pkg::ST_CLEAR: begin
            if (clear_idx_ff == LAST_SLOT) state_in = alm_pkg::ST_IDLE;
         end
         alm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (acc_status == alm_pkg::STATUS_OK) ? alm_pkg::ST_EXEC
                                                             : alm_pkg::ST_RESP;
            end
         end
         alm_pkg::ST_EXEC: begin
            state_in = exec_fail ? alm_pkg::ST_RESP : alm_pkg::ST_LINK;
         end
         alm_pkg::ST_LINK: begin
            state_in = alm_pkg::ST_RESP;
         end
         alm_pkg::ST_RESP: begin
            if (out_free) state_in = alm_pkg::ST_IDLE;
         end
         default: begin
            state_in = alm_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory ports
   always_comb begin
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      slot_in       = slot_ff;
      status_in     = status_ff;
      free_head_in  = free_head_ff;
      head_next_in  = head_next_ff;
      tail_in       = tail_ff;
      clear_idx_in  = clear_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      nx_we    = 1'b0;
      nx_wa    = slot_ff;
      nx_wd    = '0;
      pv_we    = 1'b0;
      pv_wa    = slot_ff;
      pv_wd    = '0;
      us_we    = 1'b0;
      us_wa    = slot_ff;
      us_wd    = 1'b0;
      value_we = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = (req_chan.cmd == alm_pkg::CMD_DELETE) ? IW'(req_chan.position) : free_head_ff;

      case (state_ff)
         alm_pkg::ST_CLEAR: begin
            // rebuild free chain 1 -> 2 -> ... -> last -> 0
            nx_we = 1'b1;
            nx_wa = clear_idx_ff;
            nx_wd = (clear_idx_ff != '0 && clear_idx_ff != LAST_SLOT) ? clear_idx_ff + 1'b1 : '0;
            pv_we = 1'b1;
            pv_wa = clear_idx_ff;
            us_we = 1'b1;
            us_wa = clear_idx_ff;
            clear_idx_in = clear_idx_ff + 1'b1;
         end
         alm_pkg::ST_IDLE: begin
            if (accept) begin
               rd_en     = 1'b1;
               cmd_in    = req_chan.cmd;
               value_in  = req_chan.value;
               slot_in   = rd_addr;
               status_in = acc_status;
            end
         end
         alm_pkg::ST_EXEC: begin
            if (exec_fail) begin
               status_in = (cmd_ff == alm_pkg::CMD_INSERT) ? alm_pkg::STATUS_FULL
                                                           : alm_pkg::STATUS_BAD;
            end else if (cmd_ff == alm_pkg::CMD_INSERT) begin
               nx_we        = 1'b1;
               pv_we        = 1'b1;
               pv_wd        = tail_ff;
               us_we        = 1'b1;
               us_wd        = 1'b1;
               value_we     = 1'b1;
               free_head_in = nx_rd;
            end else begin
               nx_we        = 1'b1;
               nx_wd        = free_head_ff;
               pv_we        = 1'b1;
               us_we        = 1'b1;
               free_head_in = slot_ff;
            end
         end
         alm_pkg::ST_LINK: begin
            if (cmd_ff == alm_pkg::CMD_INSERT) begin
               if (tail_ff == '0) begin
                  head_next_in = slot_ff;
               end else begin
                  nx_we = 1'b1;
                  nx_wa = tail_ff;
                  nx_wd = slot_ff;
               end
               tail_in = slot_ff;
            end else begin
               // unlink: neighbours still in the read registers
               if (pv_rd == '0) begin
                  head_next_in = nx_rd;
               end else begin
                  nx_we = 1'b1;
                  nx_wa = pv_rd;
                  nx_wd = nx_rd;
               end
               if (nx_rd == '0) begin
                  tail_in = pv_rd;
               end else begin
                  pv_we = 1'b1;
                  pv_wa = nx_rd;
                  pv_wd = pv_rd;
               end
            end
         end
         alm_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = (status_ff == alm_pkg::STATUS_OK) ? 8'(slot_ff) : 8'd0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alm_pkg::ST_CLEAR;
         clear_idx_ff <= '0;
         free_head_ff <= IW'(1);
         head_next_ff <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         free_head_ff <= free_head_in;
         head_next_ff <= head_next_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      slot_ff       <= slot_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // data words are kept but never read back
   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[slot_ff] <= DATA_WIDTH'($unsigned(value_ff));
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.slot   = rsp_slot_ff;

endmodule

`default_nettype wire

[rtl/alm_checker.sv]
// Port-level checks for the array linked list manager, bound to the top level.
// Depends on alm_pkg and array_linked_list_manager.
`default_nettype none

module alm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic [7:0] rsp_slot
);

   // a stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot))
      else $error("response item changed while stalled");

   a_err_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != alm_pkg::STATUS_OK |-> rsp_slot == 8'd0)
      else $error("error response with non-zero slot");

   // slot 0 is the sentinel, never handed out or freed
   a_ok_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == alm_pkg::STATUS_OK |-> rsp_slot != 8'd0)
      else $error("ok response names the sentinel");

   // one command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while a command is in flight");

endmodule

bind array_linked_list_manager alm_checker u_alm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_slot   (rsp_chan.slot)
);

`default_nettype wire

[tb/sv/array_linked_list_manager_test.sv]
// Self-checking testbench for array_linked_list_manager: insert/delete items are
// checked against an in-bench model of the linked list and its free chain.
// Depends on alm_pkg, alm_req_if, alm_rsp_if and the block itself.
`timescale 1ns / 100ps

module array_linked_list_manager_test;

   localparam int SLOT_COUNT     = 256;
   localparam int TOTAL_COMMANDS = 950;
   localparam int CYCLE_LIMIT    = 300000;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] slot;
   } answer_type;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_BURSTY
   } rx_mode_type;

   logic clock;
   logic reset;

   alm_req_if req_chan ();
   alm_rsp_if rsp_chan ();

   array_linked_list_manager #(
      .SLOT_COUNT(SLOT_COUNT),
      .DATA_WIDTH(32)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // list model: links, in-use bits and free chain head
   logic [7:0] model_next [SLOT_COUNT];
   logic [7:0] model_prev [SLOT_COUNT];
   logic       model_used [SLOT_COUNT];
   logic [7:0] model_free_head;

   answer_type pending_answers [$];
   answer_type oldest_answer;

   int error_count;
   int commands_sent;
   int answers_checked;
   int status_tally [4];

   logic        sender_idles;
   int          burst_left;
   rx_mode_type rx_mode;
   int          rx_hold_cycles;
   int          rx_run_left;
   logic        rx_run_level;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout, %0d answers still outstanding", $time, pending_answers.size());
      $display("Simulation FAILED");
      $finish;
   end

   task automatic clear_list_model();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         model_next[i] = (i >= 1 && i + 1 < SLOT_COUNT) ? 8'(i + 1) : 8'd0;
         model_prev[i] = 8'd0;
         model_used[i] = 1'b0;
      end
      model_free_head = 8'd1;
   endtask

   function automatic answer_type predict_list_command(logic cmd, logic [7:0] position);
      answer_type a;
      logic [7:0] s, nf, tail, p, n;
      a.status = alm_pkg::STATUS_OK;
      a.slot   = 8'd0;
      if (cmd == alm_pkg::CMD_INSERT) begin
         s = model_free_head;
         if (s == 8'd0 || model_used[s]) begin
            a.status = alm_pkg::STATUS_FULL;
         end else begin
            nf              = model_next[s];
            tail            = model_prev[0];
            model_next[s]   = 8'd0;
            model_prev[s]   = tail;
            model_next[tail] = s;
            model_prev[0]   = s;
            model_used[s]   = 1'b1;
            model_free_head = nf;
            a.slot          = s;
         end
      end else if (model_next[0] == 8'd0) begin
         // empty wins over a bad position
         a.status = alm_pkg::STATUS_EMPTY;
      end else if (position == 8'd0 || !model_used[position]) begin
         a.status = alm_pkg::STATUS_BAD;
      end else begin
         p                    = model_prev[position];
         n                    = model_next[position];
         model_next[p]        = n;
         model_prev[n]        = p;
         model_next[position] = model_free_head;
         model_prev[position] = 8'd0;
         model_used[position] = 1'b0;
         model_free_head      = position;
         a.slot               = position;
      end
      return a;
   endfunction

   // answers are checked before the item taken at the same edge is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (pending_answers.size() == 0) begin
               error_count++;
               $display("%0t: unexpected answer status %0d slot %0d", $time,
                        rsp_chan.status, rsp_chan.slot);
            end else begin
               oldest_answer = pending_answers.pop_front();
               answers_checked++;
               if (rsp_chan.status !== oldest_answer.status) begin
                  error_count++;
                  $display("%0t: status expected %0d, got %0d", $time,
                           oldest_answer.status, rsp_chan.status);
               end
               if (rsp_chan.slot !== oldest_answer.slot) begin
                  error_count++;
                  $display("%0t: slot expected %0d, got %0d", $time,
                           oldest_answer.slot, rsp_chan.slot);
               end
            end
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            oldest_answer = predict_list_command(req_chan.cmd, req_chan.position);
            status_tally[oldest_answer.status]++;
            pending_answers.push_back(oldest_answer);
         end
      end
   end

   initial begin : receiver
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            rx_hold_cycles--;
         end else begin
            case (rx_mode)
               RX_ALWAYS: begin
                  rsp_chan.ready <= 1'b1;
               end
               RX_RANDOM: begin
                  rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  if (rx_run_left == 0) begin
                     rx_run_level = ~rx_run_level;
                     rx_run_left  = rx_run_level ? $urandom_range(1, 12) : $urandom_range(1, 6);
                  end
                  rx_run_left--;
                  rsp_chan.ready <= rx_run_level;
               end
            endcase
         end
      end
   end

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_command(input logic cmd, input logic [31:0] value,
                               input logic [7:0] position);
      if (sender_idles) begin
         if (burst_left == 0) begin
            idle_sender($urandom_range(1, 10));
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
      end
      @(negedge clock);
      req_chan.valid    <= 1'b1;
      req_chan.cmd      <= cmd;
      req_chan.value    <= value;
      req_chan.position <= position;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      commands_sent++;
   endtask

   task automatic wait_all_answers();
      idle_sender(1);
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   // mostly a live slot, often the head or tail; random when the list is empty
   function automatic logic [7:0] pick_used_slot();
      logic [7:0] live [$];
      int         pick;
      if (model_next[0] == 8'd0) return 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 3);
      if (pick == 0) return model_next[0];
      if (pick == 1) return model_prev[0];
      for (int i = 1; i < SLOT_COUNT; i++)
         if (model_used[i]) live.push_back(8'(i));
      return live[$urandom_range(0, live.size() - 1)];
   endfunction

   task automatic test_directed_cases();
      sender_idles = 1'b1;
      rx_mode      = RX_RANDOM;
      send_command(alm_pkg::CMD_DELETE, $urandom, 8'd5);
      send_command(alm_pkg::CMD_DELETE, $urandom, 8'd0);
      send_command(alm_pkg::CMD_DELETE, $urandom, 8'hFF);
      send_command(alm_pkg::CMD_INSERT, 32'h7FFF_FFFF, 8'h00);
      send_command(alm_pkg::CMD_INSERT, 32'h8000_0000, 8'hFF);
      send_command(alm_pkg::CMD_INSERT, 32'h0000_0000, 8'h55);
      send_command(alm_pkg::CMD_INSERT, 32'hFFFF_FFFF, 8'hAA);
      send_command(alm_pkg::CMD_DELETE, 32'hFFFF_FFFF, 8'd0);
      send_command(alm_pkg::CMD_DELETE, 32'h0000_0000, 8'hFF);
      send_command(alm_pkg::CMD_DELETE, $urandom, 8'd200);
      // unlink from the middle, then the same slot again
      send_command(alm_pkg::CMD_DELETE, $urandom, 8'd2);
      send_command(alm_pkg::CMD_DELETE, $urandom, 8'd2);
      send_command(alm_pkg::CMD_INSERT, $urandom, 8'($urandom));
      send_command(alm_pkg::CMD_DELETE, $urandom, model_prev[0]);
      send_command(alm_pkg::CMD_DELETE, $urandom, model_next[0]);
      send_command(alm_pkg::CMD_DELETE, $urandom, 8'd4);
      send_command(alm_pkg::CMD_DELETE, $urandom, 8'd3);
      send_command(alm_pkg::CMD_DELETE, $urandom, 8'd3);
      send_command(alm_pkg::CMD_INSERT, $urandom, 8'($urandom));
      send_command(alm_pkg::CMD_DELETE, $urandom, model_next[0]);
   endtask

   task automatic test_fill_to_full();
      rx_mode = RX_BURSTY;
      while (model_free_head != 8'd0)
         send_command(alm_pkg::CMD_INSERT, $urandom, 8'($urandom));
      repeat (3) send_command(alm_pkg::CMD_INSERT, $urandom, 8'($urandom));
      send_command(alm_pkg::CMD_DELETE, $urandom, pick_used_slot());
      send_command(alm_pkg::CMD_INSERT, $urandom, 8'($urandom));
      send_command(alm_pkg::CMD_INSERT, $urandom, 8'($urandom));
      while (model_next[0] != 8'd0)
         send_command(alm_pkg::CMD_DELETE, $urandom, pick_used_slot());
      send_command(alm_pkg::CMD_DELETE, $urandom, 8'($urandom));
   endtask

   task automatic test_receiver_hold_off();
      wait_all_answers();
      sender_idles   = 1'b0;
      rx_hold_cycles = 150;
      repeat (12) send_command($urandom_range(0, 2) == 0 ? alm_pkg::CMD_DELETE
                                                         : alm_pkg::CMD_INSERT,
                               $urandom, pick_used_slot());
      wait_all_answers();
   endtask

   task automatic test_random_mix();
      logic grow;
      int   phase_len;
      grow = 1'b0;
      while (commands_sent < TOTAL_COMMANDS) begin
         grow         = ~grow;
         phase_len    = $urandom_range(20, 80);
         sender_idles = ($urandom_range(0, 3) != 0);
         rx_mode      = rx_mode_type'($urandom_range(0, 2));
         repeat (phase_len) begin
            if ($urandom_range(0, 99) < (grow ? 75 : 25))
               send_command(alm_pkg::CMD_INSERT, $urandom, 8'($urandom));
            else if ($urandom_range(0, 99) < 85)
               send_command(alm_pkg::CMD_DELETE, $urandom, pick_used_slot());
            else
               send_command(alm_pkg::CMD_DELETE, $urandom, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.cmd      = alm_pkg::CMD_INSERT;
      req_chan.value    = '0;
      req_chan.position = '0;
      error_count       = 0;
      commands_sent     = 0;
      answers_checked   = 0;
      status_tally      = '{default: 0};
      sender_idles      = 1'b0;
      burst_left        = 0;
      rx_mode           = RX_ALWAYS;
      rx_hold_cycles    = 0;
      rx_run_left       = 0;
      rx_run_level      = 1'b0;
      clear_list_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_fill_to_full();
      test_receiver_hold_off();
      test_random_mix();

      wait_all_answers();
      repeat (20) @(posedge clock);
      $display("Sent %0d commands, checked %0d answers: ok %0d, full %0d, empty %0d, bad %0d.",
               commands_sent, answers_checked, status_tally[alm_pkg::STATUS_OK],
               status_tally[alm_pkg::STATUS_FULL], status_tally[alm_pkg::STATUS_EMPTY],
               status_tally[alm_pkg::STATUS_BAD]);
      $display("Covered fill to full, drain to empty, head/tail/middle unlinks and stalls.");
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
